FILE: rtl/core/cfb_pkg.sv
// Checksummed frame builder package: port payload structs, the queued command
// struct and frame layout constants. No dependencies.

package cfb_pkg;

  // Frame layout
  localparam int MAX_FRAME_BYTES_DEF = 128;
  localparam int FIXED_OVERHEAD      = 12;
  localparam int HDR_BYTES           = 4;
  localparam int LEN_BYTES           = 2;
  localparam int ID_BYTES            = 4;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [7:0] HDR_TEXT [HDR_BYTES] = '{8'h48, 8'h43, 8'h5A, 8'h4E};

  // Byte position within one frame, as the back end walks it
  localparam logic [3:0] IDX_HDR0   = 4'd0;
  localparam logic [3:0] IDX_HDR1   = 4'd1;
  localparam logic [3:0] IDX_HDR2   = 4'd2;
  localparam logic [3:0] IDX_HDR3   = 4'd3;
  localparam logic [3:0] IDX_LEN_LO = 4'd4;
  localparam logic [3:0] IDX_LEN_HI = 4'd5;
  localparam logic [3:0] IDX_ID0    = 4'd6;
  localparam logic [3:0] IDX_ID1    = 4'd7;
  localparam logic [3:0] IDX_ID2    = 4'd8;
  localparam logic [3:0] IDX_ID3    = 4'd9;
  localparam logic [3:0] IDX_DATA   = 4'd10;
  localparam logic [3:0] IDX_SUM_LO = 4'd11;
  localparam logic [3:0] IDX_SUM_HI = 4'd12;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [6:0]  payload_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
  } out_item_t;

  // One classified input item, front end to back end
  typedef struct packed {
    logic        is_start;   // frame start: header, length and ID go first
    logic [31:0] frame_id;
    logic [6:0]  len;        // saturated payload length (start items only)
    logic [7:0]  data_byte;
    logic        last;       // checksum follows this item
  } cmd_t;

endpackage

FILE: rtl/core/cfb_front.sv
// Front end: accepts input transfers, tracks frame position and turns each
// item into a command for the queue. Depends on cfb_pkg.

module cfb_front #(
  parameter int MAX_FRAME_BYTES = cfb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cfb_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             q_push,
  output cfb_pkg::cmd_t    q_cmd
);

  localparam int Bound = MAX_FRAME_BYTES - cfb_pkg::FIXED_OVERHEAD;
  localparam logic [6:0] BoundLen = (Bound > 127) ? 7'd127 : 7'(Bound);

  logic       in_frame_r, in_frame_nxt;
  logic [6:0] bytes_left_r, bytes_left_nxt;
  logic [6:0] sat_len;
  logic [6:0] left_dec;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the item and work out what is left of the frame
  always_comb begin
    sat_len        = (in_item.payload_len > BoundLen) ? BoundLen : in_item.payload_len;
    left_dec       = (bytes_left_r == 7'd0) ? 7'd0 : bytes_left_r - 7'd1;
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    q_cmd.frame_id  = in_item.frame_id;
    q_cmd.data_byte = in_item.data_byte;
    q_cmd.is_start  = !in_frame_r;
    q_cmd.len       = sat_len;
    q_cmd.last      = 1'b0;
    if (!in_frame_r) begin
      q_cmd.last = (sat_len <= 7'd1);
      if (sat_len > 7'd1) begin
        in_frame_nxt   = 1'b1;
        bytes_left_nxt = sat_len - 7'd1;
      end else begin
        bytes_left_nxt = 7'd0;
      end
    end else begin
      q_cmd.last     = (left_dec == 7'd0);
      bytes_left_nxt = left_dec;
      in_frame_nxt   = (left_dec != 7'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bytes_left_r <= 7'd0;
    end else if (q_push) begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // Outside a frame nothing can be owed
  a_idle_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> bytes_left_r == 7'd0)
    else $error("bytes_left nonzero outside a frame");

endmodule

FILE: rtl/core/cfb_fifo.sv
// Short command queue between front and back ends. Depends on cfb_pkg.

module cfb_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cfb_pkg::cmd_t head_cmd
);

  localparam int Depth = cfb_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cfb_pkg::cmd_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("command queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty command queue");

endmodule

FILE: rtl/core/cfb_back.sv
// Back end: walks the queued command byte by byte, keeps the running sum and
// drives the registered output channel. Depends on cfb_pkg.

module cfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cfb_pkg::cmd_t     head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output cfb_pkg::out_item_t out_item
);

  logic [3:0]  step_r, step_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        out_valid_r, out_valid_nxt;
  cfb_pkg::out_item_t out_item_r;

  logic [3:0]  idx;
  logic [15:0] flen;
  logic [7:0]  cur_byte;
  logic        final_byte;
  logic        load;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && final_byte;

  // Byte position within the frame for the head command
  always_comb begin
    flen = {9'd0, head_cmd.len} + 16'(cfb_pkg::FIXED_OVERHEAD);
    if (!head_cmd.is_start)
      idx = step_r + cfb_pkg::IDX_DATA;
    else if (head_cmd.len == 7'd0 && step_r >= cfb_pkg::IDX_DATA)
      idx = step_r + 4'd1;
    else
      idx = step_r;
    final_byte = head_cmd.last ? (idx == cfb_pkg::IDX_SUM_HI) : (idx == cfb_pkg::IDX_DATA);
  end

  // Byte select
  always_comb begin
    unique case (idx)
      cfb_pkg::IDX_HDR0:   cur_byte = cfb_pkg::HDR_TEXT[0];
      cfb_pkg::IDX_HDR1:   cur_byte = cfb_pkg::HDR_TEXT[1];
      cfb_pkg::IDX_HDR2:   cur_byte = cfb_pkg::HDR_TEXT[2];
      cfb_pkg::IDX_HDR3:   cur_byte = cfb_pkg::HDR_TEXT[3];
      cfb_pkg::IDX_LEN_LO: cur_byte = flen[7:0];
      cfb_pkg::IDX_LEN_HI: cur_byte = flen[15:8];
      cfb_pkg::IDX_ID0:    cur_byte = head_cmd.frame_id[7:0];
      cfb_pkg::IDX_ID1:    cur_byte = head_cmd.frame_id[15:8];
      cfb_pkg::IDX_ID2:    cur_byte = head_cmd.frame_id[23:16];
      cfb_pkg::IDX_ID3:    cur_byte = head_cmd.frame_id[31:24];
      cfb_pkg::IDX_DATA:   cur_byte = head_cmd.data_byte;
      cfb_pkg::IDX_SUM_LO: cur_byte = sum_r[7:0];
      cfb_pkg::IDX_SUM_HI: cur_byte = sum_r[15:8];
      default:             cur_byte = 8'd0;
    endcase
  end

  // Next step, running sum and output register
  always_comb begin
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = final_byte ? 4'd0 : step_r + 4'd1;
      if (idx == cfb_pkg::IDX_SUM_HI)
        sum_nxt = 16'd0;
      else if (idx <= cfb_pkg::IDX_DATA)
        sum_nxt = ((idx == cfb_pkg::IDX_HDR0) ? 16'd0 : sum_r) + {8'd0, cur_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      sum_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.out_byte  <= cur_byte;
      out_item_r.run_end   <= final_byte;
      out_item_r.frame_end <= (idx == cfb_pkg::IDX_SUM_HI);
    end
  end

  a_fend_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.frame_end |-> out_item_r.run_end)
    else $error("frame end not on last byte of an item");

  a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> step_r == 4'd0)
    else $error("step not rewound after command completes");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx <= cfb_pkg::IDX_SUM_HI)
    else $error("frame byte position out of range");

endmodule

FILE: rtl/core/checksummed_frame_builder.sv
// Checksummed frame builder top level: front end, command queue, back end.
// Depends on cfb_pkg, cfb_front, cfb_fifo and cfb_back.
//
//   channel | ports                          | direction | moves
//   input   | in_valid, in_stall, in_item    | in        | one packet item per transfer
//   output  | out_valid, out_stall, out_item | out       | one frame byte per transfer
//
// The output emits one byte per cycle when not stalled and a command is queued;
// a payload item yields its data byte, a start item the header, length, ID and
// data byte (no data byte if the payload is empty), the last item also the two
// checksum bytes. The back end's single output register sets that rate. A 4-entry
// command queue lets input transfers continue while header bytes drain. Reset is
// synchronous, active low; no clearing pass. in_stall rises only on a full queue.

module checksummed_frame_builder #(
  parameter int MAX_FRAME_BYTES = cfb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cfb_pkg::out_item_t out_item
);

  logic          q_push, q_full, q_pop, q_head_valid;
  cfb_pkg::cmd_t q_cmd, q_head;

  cfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  cfb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  cfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
